/* sv/gmp_pkg.sv */
// ----------------------------------------------------------------------------
// Grid max path package
// Shared constants, the sequencer state type and the result record type.
// ----------------------------------------------------------------------------
package gmp_pkg;

   localparam int GRID_MAX_DEF = 16;
   localparam int GRID_MIN     = 2;

   localparam int               GRID_SIZE_W   = 5;
   localparam logic [4:0]       GRID_SIZE_RST = 5'd16;

   localparam int TOTAL_W   = 5;
   localparam int TOTAL_MAX = 31;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic KIND_TOTAL = 1'b0;
   localparam logic KIND_MOVE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_WALK_RD,
      ST_WALK_STEP,
      ST_EMIT_TOTAL,
      ST_EMIT_MOVE
   } gmp_state_type;

   typedef struct packed {
      logic               kind;
      logic [TOTAL_W-1:0] total;
      logic               move_right;
      logic               last;
   } gmp_rec_type;

endpackage

/* sv/gmp_ram.sv */
// ----------------------------------------------------------------------------
// Grid max path RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gmp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/gmp_ctrl.sv */
// ----------------------------------------------------------------------------
// Grid max path sequencer
// Loads cells, sweeps the grid through the node memory, walks the traceback
// bits back to the origin and hands out the result records in order.
// ----------------------------------------------------------------------------
module gmp_ctrl #(
   parameter int GRID_MAX = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [$clog2(GRID_MAX+1)-1:0]           n_eff,
   input  logic [$clog2(GRID_MAX*GRID_MAX):0]      total_cells,
   input  logic                                    req_accept,
   input  logic                                    req_cell_bit,
   input  logic                                    req_last_cell,
   output logic                                    busy,
   output logic                                    cell_we,
   output logic [$clog2(GRID_MAX*GRID_MAX)-1:0]    cell_waddr,
   output logic                                    cell_wdata,
   output logic [$clog2(GRID_MAX*GRID_MAX)-1:0]    cell_raddr,
   input  logic                                    cell_rdata,
   output logic                                    node_we,
   output logic [$clog2(GRID_MAX*GRID_MAX)-1:0]    node_waddr,
   output logic [$clog2(2*GRID_MAX):0]             node_wdata,
   output logic [$clog2(GRID_MAX*GRID_MAX)-1:0]    node_raddr,
   input  logic [$clog2(2*GRID_MAX):0]             node_rdata,
   input  logic                                    rec_free,
   output logic                                    rec_valid,
   output gmp_pkg::gmp_rec_type                    rec
);

   import gmp_pkg::*;

   localparam int ADDR_W  = $clog2(GRID_MAX*GRID_MAX);
   localparam int COORD_W = $clog2(GRID_MAX);
   localparam int N_W     = $clog2(GRID_MAX+1);
   localparam int SUM_W   = $clog2(2*GRID_MAX);
   localparam int STACK_W = 2*GRID_MAX-2;

   gmp_state_type state_ff, state_in;

   logic [ADDR_W:0]        load_index_ff, load_index_in, load_idx;
   logic [ADDR_W-1:0]      sw_p_ff, sw_p_in;
   logic [COORD_W-1:0]     sw_x_ff, sw_x_in, sw_y_ff, sw_y_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]      s1_p_ff, s1_p_in;
   logic [COORD_W-1:0]     s1_x_ff, s1_x_in, s1_y_ff, s1_y_in;
   logic [SUM_W-1:0]       left_sum_ff, left_sum_in;
   logic [SUM_W-1:0]       best_ff, best_in;
   logic [ADDR_W-1:0]      pick_p_ff, pick_p_in;
   logic [COORD_W-1:0]     pick_x_ff, pick_x_in, pick_y_ff, pick_y_in;
   logic [SUM_W-1:0]       mcount_ff, mcount_in;
   logic [STACK_W-1:0]     stack_ff, stack_in;

   logic [COORD_W-1:0]     n_last;
   logic [SUM_W-1:0]       l_sum, u_sum, new_sum;
   logic                   new_cfl;
   logic [TOTAL_W-1:0]     total_sat;

   assign n_last   = COORD_W'(n_eff - N_W'(1));
   assign load_idx = (load_index_ff >= total_cells) ? '0 : load_index_ff;

   assign cell_we    = req_accept;
   assign cell_waddr = load_idx[ADDR_W-1:0];
   assign cell_wdata = req_cell_bit;
   assign cell_raddr = sw_p_ff;

   assign busy = (state_ff != ST_IDLE);

   assign total_sat = (int'(best_ff) > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX)
                                                  : TOTAL_W'(best_ff);

   // Best sum of the cell whose memory reads were issued last cycle.
   always_comb begin
      l_sum = left_sum_ff + SUM_W'(cell_rdata);
      u_sum = node_rdata[SUM_W-1:0] + SUM_W'(cell_rdata);
      if (s1_p_ff == '0) begin
         new_sum = SUM_W'(cell_rdata);
         new_cfl = 1'b0;
      end else if (s1_y_ff == '0) begin
         new_sum = l_sum;
         new_cfl = 1'b1;
      end else if (s1_x_ff == '0) begin
         new_sum = u_sum;
         new_cfl = 1'b0;
      end else if ((u_sum > l_sum) || (l_sum == '0)) begin
         new_sum = u_sum;
         new_cfl = 1'b0;
      end else begin
         new_sum = l_sum;
         new_cfl = 1'b1;
      end
   end

   assign node_we    = s1_valid_ff;
   assign node_waddr = s1_p_ff;
   assign node_wdata = {new_cfl, new_sum};

   always_comb begin
      state_in      = state_ff;
      load_index_in = load_index_ff;
      sw_p_in       = sw_p_ff;
      sw_x_in       = sw_x_ff;
      sw_y_in       = sw_y_ff;
      s1_valid_in   = 1'b0;
      s1_p_in       = sw_p_ff;
      s1_x_in       = sw_x_ff;
      s1_y_in       = sw_y_ff;
      left_sum_in   = left_sum_ff;
      best_in       = best_ff;
      pick_p_in     = pick_p_ff;
      pick_x_in     = pick_x_ff;
      pick_y_in     = pick_y_ff;
      mcount_in     = mcount_ff;
      stack_in      = stack_ff;
      node_raddr    = sw_p_ff - ADDR_W'(n_eff);
      rec_valid     = 1'b0;
      rec.kind       = KIND_TOTAL;
      rec.total      = total_sat;
      rec.move_right = 1'b0;
      rec.last       = (mcount_ff == '0);

      if (req_accept) begin
         load_index_in = req_last_cell ? '0 : load_idx + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_last_cell) begin
               sw_p_in   = '0;
               sw_x_in   = '0;
               sw_y_in   = '0;
               best_in   = '0;
               pick_p_in = '0;
               pick_x_in = '0;
               pick_y_in = '0;
               mcount_in = '0;
               state_in  = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            s1_valid_in = 1'b1;
            sw_p_in     = sw_p_ff + 1'b1;
            if (sw_x_ff == n_last) begin
               sw_x_in = '0;
               sw_y_in = sw_y_ff + 1'b1;
               if (sw_y_ff == n_last) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               sw_x_in = sw_x_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WALK_RD;
         end
         ST_WALK_RD: begin
            node_raddr = pick_p_ff;
            if ((pick_x_ff == '0) && (pick_y_ff == '0)) begin
               state_in = ST_EMIT_TOTAL;
            end else begin
               state_in = ST_WALK_STEP;
            end
         end
         ST_WALK_STEP: begin
            stack_in  = {stack_ff[STACK_W-2:0], node_rdata[SUM_W]};
            mcount_in = mcount_ff + 1'b1;
            if (node_rdata[SUM_W]) begin
               pick_p_in = pick_p_ff - 1'b1;
               pick_x_in = pick_x_ff - 1'b1;
            end else begin
               pick_p_in = pick_p_ff - ADDR_W'(n_eff);
               pick_y_in = pick_y_ff - 1'b1;
            end
            state_in = ST_WALK_RD;
         end
         ST_EMIT_TOTAL: begin
            rec_valid = 1'b1;
            if (rec_free) begin
               state_in = (mcount_ff == '0) ? ST_IDLE : ST_EMIT_MOVE;
            end
         end
         ST_EMIT_MOVE: begin
            rec_valid      = 1'b1;
            rec.kind       = KIND_MOVE;
            rec.total      = '0;
            rec.move_right = stack_ff[0];
            rec.last       = (mcount_ff == SUM_W'(1));
            if (rec_free) begin
               stack_in  = stack_ff >> 1;
               mcount_in = mcount_ff - 1'b1;
               if (mcount_ff == SUM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The highest-indexed non-origin cell with the largest nonzero sum wins.
      if (s1_valid_ff) begin
         left_sum_in = new_sum;
         if ((s1_p_ff != '0) && (new_sum != '0) && (new_sum >= best_ff)) begin
            best_in   = new_sum;
            pick_p_in = s1_p_ff;
            pick_x_in = s1_x_ff;
            pick_y_in = s1_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff <= '0;
         s1_valid_ff   <= 1'b0;
         mcount_ff     <= '0;
      end else begin
         load_index_ff <= load_index_in;
         s1_valid_ff   <= s1_valid_in;
         mcount_ff     <= mcount_in;
      end
   end

   always_ff @(posedge clock) begin
      sw_p_ff     <= sw_p_in;
      sw_x_ff     <= sw_x_in;
      sw_y_ff     <= sw_y_in;
      s1_p_ff     <= s1_p_in;
      s1_x_ff     <= s1_x_in;
      s1_y_ff     <= s1_y_in;
      left_sum_ff <= left_sum_in;
      best_ff     <= best_in;
      pick_p_ff   <= pick_p_in;
      pick_x_ff   <= pick_x_in;
      pick_y_ff   <= pick_y_in;
      stack_ff    <= stack_in;
   end

endmodule

/* sv/grid_max_path_with_traceback.sv */
// ----------------------------------------------------------------------------
// Grid max path with traceback
// Top level: configuration port, cell and node memories, sequencer and the
// result output register.
// ----------------------------------------------------------------------------
// Cells are taken one item per cycle while the block is idle. The item marked
// last_cell starts a run: the sweep takes one cell a cycle through the node
// memory, whose single read port also serves the traceback, which reads and
// then steps once per move. Records leave the output register one per cycle
// while rsp_stall is low: the total first, then the moves from the origin.
// Input stays stalled from the last cell until the final record is loaded
// into the output register. The memories need no clearing pass after reset.
module grid_max_path_with_traceback #(
   parameter int GRID_MAX = gmp_pkg::GRID_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cell_bit,
   input  logic                             req_last_cell,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_record_kind,
   output logic [gmp_pkg::TOTAL_W-1:0]      rsp_best_total,
   output logic                             rsp_move_right,
   output logic                             rsp_last,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gmp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [gmp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [gmp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   import gmp_pkg::*;

   localparam int CELLS  = GRID_MAX*GRID_MAX;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int N_W    = $clog2(GRID_MAX+1);
   localparam int SUM_W  = $clog2(2*GRID_MAX);

   logic [GRID_SIZE_W-1:0] grid_size_ff;
   logic                   csr_sel;
   logic [N_W-1:0]         n_eff;
   logic [ADDR_W:0]        n_wide, total_cells;

   logic                   busy, req_accept;
   logic                   cell_we, cell_wdata, cell_rdata;
   logic [ADDR_W-1:0]      cell_waddr, cell_raddr;
   logic                   node_we;
   logic [ADDR_W-1:0]      node_waddr, node_raddr;
   logic [SUM_W:0]         node_wdata, node_rdata;

   logic                   rec_valid, rec_free;
   gmp_rec_type            rec;
   logic                   rsp_valid_ff;
   gmp_rec_type            rsp_rec_ff;

   assign csr_sel = (paddr[CSR_ADDR_W-1:2] == '0);
   assign pready  = 1'b1;
   assign prdata  = csr_sel ? CSR_DATA_W'(grid_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_SIZE_RST;
      end else if (psel && penable && pwrite && pready && csr_sel) begin
         grid_size_ff <= pwdata[GRID_SIZE_W-1:0];
      end
   end

   always_comb begin
      if (int'(grid_size_ff) < GRID_MIN) begin
         n_eff = N_W'(GRID_MIN);
      end else if (int'(grid_size_ff) > GRID_MAX) begin
         n_eff = N_W'(GRID_MAX);
      end else begin
         n_eff = N_W'(grid_size_ff);
      end
   end

   assign n_wide      = (ADDR_W+1)'(n_eff);
   assign total_cells = n_wide * n_wide;

   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;

   gmp_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   gmp_ram #(
      .WIDTH (SUM_W+1),
      .DEPTH (CELLS)
   ) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (node_waddr),
      .wdata (node_wdata),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   gmp_ctrl #(
      .GRID_MAX (GRID_MAX)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .n_eff         (n_eff),
      .total_cells   (total_cells),
      .req_accept    (req_accept),
      .req_cell_bit  (req_cell_bit),
      .req_last_cell (req_last_cell),
      .busy          (busy),
      .cell_we       (cell_we),
      .cell_waddr    (cell_waddr),
      .cell_wdata    (cell_wdata),
      .cell_raddr    (cell_raddr),
      .cell_rdata    (cell_rdata),
      .node_we       (node_we),
      .node_waddr    (node_waddr),
      .node_wdata    (node_wdata),
      .node_raddr    (node_raddr),
      .node_rdata    (node_rdata),
      .rec_free      (rec_free),
      .rec_valid     (rec_valid),
      .rec           (rec)
   );

   assign rec_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rec_free) begin
         rsp_valid_ff <= rec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_free && rec_valid) begin
         rsp_rec_ff <= rec;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_record_kind = rsp_rec_ff.kind;
   assign rsp_best_total  = rsp_rec_ff.total;
   assign rsp_move_right  = rsp_rec_ff.move_right;
   assign rsp_last        = rsp_rec_ff.last;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Grid max path with traceback testbench
// Loads grids of one-bit cells through the item channel and checks every
// result record (best total, then the moves from the origin) against a
// predictor in this file or a typed directed row. Grid sizes change between
// phases via the configuration port; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import gmp_pkg::*;

   localparam int GRID_MAX       = GRID_MAX_DEF;
   localparam int CELLS          = GRID_MAX * GRID_MAX;
   localparam int PRELOAD_SIZE   = 8;
   localparam int RANDOM_ITEMS   = 185;
   localparam int DRAIN_CYCLES   = 4;
   localparam int END_CYCLES     = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AFTER     = 20;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_MAX     = 10;

   localparam logic [CSR_ADDR_W-1:0] ADDR_GRID_SIZE = '0;

   typedef enum logic {ROW_CFG, ROW_CELL} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [4:0]   value;
      logic         fin;
      logic         typed;
      logic [4:0]   total;
      logic [2:0]   nmoves;
      logic [3:0]   moves;
   } dir_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_cell_bit = 1'b0;
   logic                      req_last_cell = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_record_kind;
   logic [TOTAL_W-1:0]        rsp_best_total;
   logic                      rsp_move_right;
   logic                      rsp_last;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     paddr = '0;
   logic [CSR_DATA_W-1:0]     pwdata = '0;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   logic [GRID_SIZE_W-1:0]    grid_cfg = GRID_SIZE_RST;
   bit                        cell_mem [CELLS];
   int                        path_sum [CELLS];
   bit                        from_left [CELLS];
   int                        load_pos = 0;
   gmp_rec_type               path_recs [$];
   gmp_rec_type               path_recs_due [$];
   gmp_rec_type               want_rec;

   int                        mismatches = 0;
   int                        recs_checked = 0;
   int                        cells_sent = 0;
   int                        runs_done = 0;
   int                        random_items = 0;
   int                        max_total = 0;
   int                        calm_items = 0;
   int                        hold_left = 0;
   bit                        hold_done = 1'b0;
   int                        stall_left = 0;
   int                        calm_left = 0;
   int                        idle_cycles = 0;
   bit                        sizes_seen [GRID_MAX+1];

   dir_row_type dir_rows [24] = '{
      '{ROW_CFG,  5'd2, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b1, 1'b1, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd1, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd1, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd1, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd1, 1'b1, 1'b1, 5'd3, 3'd2, 4'b0010},
      '{ROW_CELL, 5'd0, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd1, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b1, 1'b1, 5'd1, 3'd2, 4'b0001},
      '{ROW_CELL, 5'd1, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b1, 1'b1, 5'd1, 3'd2, 4'b0010},
      '{ROW_CELL, 5'd1, 1'b1, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CFG,  5'd0, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd1, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd1, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd1, 1'b0, 1'b0, 5'd0, 3'd0, 4'b0000},
      '{ROW_CELL, 5'd0, 1'b1, 1'b0, 5'd0, 3'd0, 4'b0000}
   };

   grid_max_path_with_traceback #(
      .GRID_MAX (GRID_MAX)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cell_bit    (req_cell_bit),
      .req_last_cell   (req_last_cell),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_record_kind (rsp_record_kind),
      .rsp_best_total  (rsp_best_total),
      .rsp_move_right  (rsp_move_right),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic int grid_span();
      if (grid_cfg < GRID_MIN) begin
         return GRID_MIN;
      end
      if (grid_cfg > GRID_MAX) begin
         return GRID_MAX;
      end
      return grid_cfg;
   endfunction

   function automatic void grid_best_path(input bit bit_in, input bit fin);
      int          n;
      int          cells;
      int          pos;
      int          best;
      int          pick;
      int          x;
      int          y;
      int          p;
      int          l;
      int          u;
      int          nm;
      int          i;
      bit          steps [2*GRID_MAX];
      gmp_rec_type rec;
      n = grid_span();
      cells = n * n;
      pos = load_pos;
      if (pos >= cells) begin
         pos = 0;
      end
      cell_mem[pos] = bit_in;
      load_pos = pos + 1;
      path_recs.delete();
      if (!fin) begin
         return;
      end
      load_pos = 0;
      for (p = 0; p < cells; p++) begin
         x = p % n;
         y = p / n;
         if (p == 0) begin
            path_sum[0] = cell_mem[0];
            from_left[0] = 1'b0;
         end else if (y == 0) begin
            path_sum[p] = path_sum[p-1] + cell_mem[p];
            from_left[p] = 1'b1;
         end else if (x == 0) begin
            path_sum[p] = path_sum[p-n] + cell_mem[p];
            from_left[p] = 1'b0;
         end else begin
            l = path_sum[p-1] + cell_mem[p];
            u = path_sum[p-n] + cell_mem[p];
            if (u > l || l == 0) begin
               path_sum[p] = u;
               from_left[p] = 1'b0;
            end else begin
               path_sum[p] = l;
               from_left[p] = 1'b1;
            end
         end
      end
      best = 0;
      pick = 0;
      for (p = cells - 1; p > 0; p--) begin
         if (path_sum[p] > best) begin
            best = path_sum[p];
            pick = p;
         end
      end
      if (best > TOTAL_MAX) begin
         best = TOTAL_MAX;
      end
      nm = 0;
      if (pick != 0) begin
         x = pick % n;
         y = pick / n;
         while ((x != 0 || y != 0) && nm < 2 * GRID_MAX) begin
            p = x + y * n;
            steps[nm] = from_left[p];
            nm = nm + 1;
            if (from_left[p]) begin
               x = x - 1;
            end else begin
               y = y - 1;
            end
         end
      end
      rec.kind = KIND_TOTAL;
      rec.total = best[TOTAL_W-1:0];
      rec.move_right = 1'b0;
      rec.last = (nm == 0);
      path_recs = {path_recs, rec};
      for (i = nm; i > 0; i--) begin
         rec.kind = KIND_MOVE;
         rec.total = '0;
         rec.move_right = steps[i-1];
         rec.last = (i == 1);
         path_recs = {path_recs, rec};
      end
   endfunction

   task automatic send_cell(input bit bit_in, input bit fin, input bit typed,
                            input logic [4:0] total, input int nmoves,
                            input logic [3:0] moves);
      gmp_rec_type rec;
      int          gap;
      int          i;
      req_valid <= 1'b1;
      req_cell_bit <= bit_in;
      req_last_cell <= fin;
      do @(posedge clock); while (req_stall);
      grid_best_path(bit_in, fin);
      if (typed) begin
         rec.kind = KIND_TOTAL;
         rec.total = total;
         rec.move_right = 1'b0;
         rec.last = (nmoves == 0);
         path_recs_due = {path_recs_due, rec};
         for (i = 0; i < nmoves; i++) begin
            rec.kind = KIND_MOVE;
            rec.total = '0;
            rec.move_right = moves[i];
            rec.last = (i == nmoves - 1);
            path_recs_due = {path_recs_due, rec};
         end
      end else begin
         foreach (path_recs[i]) begin
            path_recs_due = {path_recs_due, path_recs[i]};
         end
      end
      cells_sent++;
      if (fin) begin
         runs_done++;
      end
      if (calm_items > 0) begin
         calm_items--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            calm_items = $urandom_range(5, 30);
         end
         gap = $urandom_range(0, 1) ? gap_len() : 0;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic set_grid(input logic [4:0] value);
      req_valid <= 1'b0;
      while (path_recs_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_GRID_SIZE;
      pwdata <= ($urandom() & 32'hFFFF_FFE0) | value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      grid_cfg = value;
      sizes_seen[grid_span()] = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (path_recs_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("unexpected record: kind %0d total %0d right %0d last %0d",
                        rsp_record_kind, rsp_best_total, rsp_move_right, rsp_last);
            end
         end else begin
            want_rec = path_recs_due[0];
            path_recs_due.delete(0);
            recs_checked++;
            if (want_rec.kind == KIND_TOTAL && want_rec.total > max_total) begin
               max_total = want_rec.total;
            end
            if (rsp_record_kind !== want_rec.kind || rsp_best_total !== want_rec.total ||
                rsp_move_right !== want_rec.move_right || rsp_last !== want_rec.last) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("record mismatch: expected kind %0d total %0d right %0d last %0d,",
                           want_rec.kind, want_rec.total, want_rec.move_right,
                           want_rec.last);
                  $display("                 got      kind %0d total %0d right %0d last %0d",
                           rsp_record_kind, rsp_best_total, rsp_move_right, rsp_last);
               end
            end
         end
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && recs_checked >= HOLD_AFTER && req_valid && req_stall) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (calm_left > 0) begin
         rsp_stall <= 1'b0;
         calm_left--;
      end else begin
         rsp_stall <= 1'b0;
         calm_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
         stall_left = gap_len();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d records outstanding",
                  idle_cycles, path_recs_due.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int         i;
      int         n;
      int         len;
      int         mode;
      int         dens;
      int         sizes;
      bit         fin_run;
      logic [4:0] size_val;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            set_grid(dir_rows[i].value);
         end else begin
            send_cell(dir_rows[i].value[0], dir_rows[i].fin, dir_rows[i].typed,
                      dir_rows[i].total, dir_rows[i].nmoves, dir_rows[i].moves);
         end
      end

      // A full grid at the largest size used below leaves every cell that
      // later runs can read written, so runs started early read loaded cells.
      set_grid(5'(PRELOAD_SIZE));
      for (i = 0; i < PRELOAD_SIZE * PRELOAD_SIZE; i++) begin
         send_cell(1'b1, i == PRELOAD_SIZE * PRELOAD_SIZE - 1, 1'b0, '0, 0, '0);
      end

      while (random_items < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         if (mode < 2) begin
            size_val = 5'($urandom_range(0, PRELOAD_SIZE));
         end else if (mode < 4) begin
            size_val = $urandom_range(0, 1) ? 5'd2 : 5'(PRELOAD_SIZE);
         end else begin
            size_val = 5'($urandom_range(2, 6));
         end
         set_grid(size_val);
         repeat ($urandom_range(2, 5)) begin
            n = grid_span();
            mode = $urandom_range(0, 99);
            dens = $urandom_range(0, 4);
            fin_run = (mode < 85);
            if (mode < 70) begin
               len = (n * n <= 64) ? n * n : $urandom_range(1, 24);
            end else if (mode < 85) begin
               len = $urandom_range(1, n * n);
            end else begin
               len = $urandom_range(1, n * n + 4);
            end
            if (len > RANDOM_ITEMS - random_items) begin
               len = RANDOM_ITEMS - random_items;
            end
            for (i = 0; i < len; i++) begin
               send_cell($urandom_range(0, 3) < dens, fin_run && i == len - 1,
                         1'b0, '0, 0, '0);
               random_items++;
            end
         end
      end

      req_valid <= 1'b0;
      while (path_recs_due.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      sizes = 0;
      foreach (sizes_seen[i]) begin
         sizes += sizes_seen[i];
      end
      $display("Covered %0d cells in %0d grid runs, %0d records checked, %0d mismatches.",
               cells_sent, runs_done, recs_checked, mismatches);
      $display("Used %0d distinct grid sizes; the largest total seen was %0d.",
               sizes, max_total);
      if (mismatches == 0 && path_recs_due.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
